/* sv/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int REG_W     = 18;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_STOP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MED_START = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MED_STOP  = CFG_IDX_W'(3);

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OOM       = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;
  localparam logic [1:0] STATUS_UNALIGNED = 2'd3;

  localparam logic [ADDR_W-1:0] FREE_LIMIT = 32'hFFFF_C000;
  localparam logic [7:0]        BYTE_FULL  = 8'hFF;
  localparam logic [7:0]        FIRST_BIT  = 8'h80;

  typedef struct packed {
    logic [REG_W-1:0] low_start;
    logic [REG_W-1:0] low_stop;
    logic [REG_W-1:0] med_start;
    logic [REG_W-1:0] med_stop;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    low_start: REG_W'(0),
    low_stop:  REG_W'(512),
    med_start: REG_W'(512),
    med_stop:  REG_W'(131072)
  };

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_DIV,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/bitmap_page_allocator_top.sv */
// Top level of the bitmap page allocator: configuration registers and result register.
//
// Requests enter on in_valid/in_ready with mode, region and page_address;
// results leave on out_valid/out_ready with result_address and status,
// exactly one result per request, in order. Region bounds are written on the
// cfg_valid/cfg_ready port (cfg_index, cfg_data), whose cfg_ready is always high;
// the user writes only while no request is in flight; the block does not enforce it.
// The block handles one request at a time. An allocate request reads
// the bytes of its region, one byte per cycle, from the bitmap memory
// (one read and one write port) and writes the chosen byte back with
// the new bit set; for an empty region no byte is read. A free request
// reads and rewrites its byte unless the address is rejected; a shift and
// a mask split the address into page and offset. With the receiver ready,
// the next request can be accepted in the cycle in which the result appears.
// After reset the bitmap memory is swept to all ones, one byte per cycle,
// so in_ready stays low until all BITMAP_BYTES bytes are set (131072 by default).
// A finished result sits in the output register; while the receiver
// stalls, in_ready is high again but the next result waits until the
// held one is taken.
`default_nettype none

module bitmap_page_allocator_top #(
  parameter int BITMAP_BYTES = 131072,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpa_pkg::REG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic                             region,
  input  logic [bpa_pkg::ADDR_W-1:0]       page_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]       result_address,
  output logic [1:0]                       status
);

  bpa_pkg::cfg_t cfg;
  bpa_pkg::res_t res;
  logic          res_valid;
  logic          res_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bpa_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpa_pkg::REG_LOW_START: cfg.low_start <= cfg_data;
        bpa_pkg::REG_LOW_STOP:  cfg.low_stop  <= cfg_data;
        bpa_pkg::REG_MED_START: cfg.med_start <= cfg_data;
        bpa_pkg::REG_MED_STOP:  cfg.med_stop  <= cfg_data;
        default:                ;
      endcase
    end
  end

  bpa_core #(
    .BITMAP_BYTES (BITMAP_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .region       (region),
    .page_address (page_address),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // The core hands over a result when the output register is empty or drains now.
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      result_address <= res.address;
      status         <= res.status;
    end
  end

endmodule

`default_nettype wire

/* sv/bpa_divider.sv */
// Splits a 32-bit address into page number and offset within the page.
`default_nettype none

module bpa_divider #(
  parameter int DIVISOR = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 dividend,
  output logic                        done,
  output logic [31:0]                 quotient,
  output logic [$clog2(DIVISOR):0]    remainder
);

  // The page size is a power of two, so the split is a shift and a mask.
  localparam int          SHIFT    = $clog2(DIVISOR);
  localparam int          RM_W     = SHIFT + 1;
  localparam logic [31:0] OFS_MASK = 32'(DIVISOR - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> SHIFT;
      remainder <= RM_W'(dividend & OFS_MASK);
    end
  end

endmodule

`default_nettype wire

/* sv/bpa_core.sv */
// Sequencer, bitmap memory and scan datapath of the page allocator.
`default_nettype none

module bpa_core #(
  parameter int BITMAP_BYTES = 131072,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpa_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic                          region,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_address,
  output logic                          res_valid,
  input  logic                          res_take,
  output bpa_pkg::res_t                 res
);

  localparam int IDX_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int PN_W   = IDX_W + 3;
  localparam int PB_W   = $clog2(PAGE_BYTES) + 1;
  localparam int PROD_W = PN_W + PB_W;
  localparam int CW     = bpa_pkg::REG_W;
  localparam logic [CW-1:0]    MAP_LIMIT = CW'(BITMAP_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BITMAP_BYTES - 1);
  localparam logic [28:0]      MAP_PAGES = 29'(BITMAP_BYTES);

  function automatic logic [2:0] first_clear(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    // The last clear bit found wins, which is the most significant clear bit.
    for (int i = 0; i < 8; i++) begin
      if (!b[i]) pos = 3'(7 - i);
    end
    return pos;
  endfunction

  bpa_pkg::state_t state, state_next;

  logic [7:0]       mem [BITMAP_BYTES];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en;

  logic [CW-1:0]    ptr;
  logic [CW-1:0]    stop_lim;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] clr_ptr;
  logic [7:0]       byte_q;
  logic [2:0]       bit_sel;
  logic [31:0]      addr_q;

  logic              accept;
  logic              hit;
  logic              can_issue;
  logic              clr_last;
  logic              scan_miss;
  logic [2:0]        alloc_bit;
  logic [7:0]        alloc_mask;
  logic [7:0]        free_mask;
  logic [PROD_W-1:0] prod;
  logic [CW-1:0]     start_sel;
  logic [CW-1:0]     stop_sel;

  logic              div_start;
  logic              div_done;
  logic [31:0]       div_quo;
  logic [PB_W-1:0]   div_rem;
  logic              range_err;
  logic              unaligned;

  bpa_divider #(.DIVISOR(PAGE_BYTES)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (page_address),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign accept     = in_valid && in_ready;
  assign hit        = chk_valid && (rd_data != bpa_pkg::BYTE_FULL);
  assign can_issue  = ptr < stop_lim;
  assign scan_miss  = !hit && !can_issue && !chk_valid;
  assign clr_last   = clr_ptr == LAST_IDX;
  assign alloc_bit  = first_clear(byte_q);
  assign alloc_mask = bpa_pkg::FIRST_BIT >> alloc_bit;
  assign free_mask  = bpa_pkg::FIRST_BIT >> bit_sel;
  assign prod       = PROD_W'({idx, alloc_bit}) * PROD_W'(PAGE_BYTES);
  assign start_sel  = region ? cfg.med_start : cfg.low_start;
  assign stop_sel   = region ? cfg.med_stop : cfg.low_stop;
  assign range_err  = (addr_q == '0) || (addr_q >= bpa_pkg::FREE_LIMIT) ||
                      (div_quo[31:3] >= MAP_PAGES);
  assign unaligned  = div_rem != '0;

  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::ST_CLEAR:    if (clr_last) state_next = bpa_pkg::ST_IDLE;
      bpa_pkg::ST_IDLE: begin
        if (accept) state_next = mode ? bpa_pkg::ST_DIV : bpa_pkg::ST_SCAN;
      end
      bpa_pkg::ST_SCAN: begin
        if (hit) state_next = bpa_pkg::ST_ALLOC_WR;
        else if (scan_miss) state_next = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_ALLOC_WR: state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (range_err || unaligned) ? bpa_pkg::ST_DONE : bpa_pkg::ST_FREE_RD;
        end
      end
      bpa_pkg::ST_FREE_RD:  state_next = bpa_pkg::ST_FREE_WR;
      bpa_pkg::ST_FREE_WR:  state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_DONE:     if (res_take) state_next = bpa_pkg::ST_IDLE;
      default:              state_next = bpa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = byte_q | alloc_mask;
    rd_addr   = idx;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      bpa_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ptr;
        wr_data = bpa_pkg::BYTE_FULL;
      end
      bpa_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = accept && mode;
      end
      bpa_pkg::ST_SCAN:     rd_addr = ptr[IDX_W-1:0];
      bpa_pkg::ST_ALLOC_WR: wr_en = 1'b1;
      bpa_pkg::ST_DIV:      ;
      bpa_pkg::ST_FREE_RD:  ;
      bpa_pkg::ST_FREE_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~free_mask;
      end
      bpa_pkg::ST_DONE:     res_valid = 1'b1;
      default:              ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::ST_CLEAR;
      clr_ptr   <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bpa_pkg::ST_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (accept) begin
        chk_valid <= 1'b0;
      end else if (state == bpa_pkg::ST_SCAN && !hit) begin
        chk_valid <= can_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bpa_pkg::ST_IDLE: begin
        if (accept) begin
          ptr      <= start_sel;
          stop_lim <= (stop_sel > MAP_LIMIT) ? MAP_LIMIT : stop_sel;
          addr_q   <= page_address;
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (hit) begin
          idx    <= chk_idx;
          byte_q <= rd_data;
        end else if (can_issue) begin
          chk_idx <= ptr[IDX_W-1:0];
          ptr     <= ptr + 1'b1;
        end else if (!chk_valid) begin
          res <= '{address: '0, status: bpa_pkg::STATUS_OOM};
        end
      end
      bpa_pkg::ST_ALLOC_WR: begin
        res <= '{address: 32'(prod), status: bpa_pkg::STATUS_OK};
      end
      bpa_pkg::ST_DIV: begin
        if (div_done) begin
          if (range_err) begin
            res <= '{address: '0, status: bpa_pkg::STATUS_RANGE};
          end else if (unaligned) begin
            res <= '{address: '0, status: bpa_pkg::STATUS_UNALIGNED};
          end else begin
            idx     <= div_quo[IDX_W+2:3];
            bit_sel <= div_quo[2:0];
          end
        end
      end
      bpa_pkg::ST_FREE_WR: begin
        res <= '{address: '0, status: bpa_pkg::STATUS_OK};
      end
      default: ;
    endcase
  end

  // An allocation always sets a bit that was clear in the byte it read.
  assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::ST_ALLOC_WR) |-> (wr_data != byte_q))
    else $error("allocation write does not set a new bit");

  // The byte chosen for an allocation lies inside the bitmap.
  assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::ST_ALLOC_WR) |-> (32'(idx) < 32'(BITMAP_BYTES)))
    else $error("allocated byte index beyond bitmap");

  // A result with a status other than OK carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != bpa_pkg::STATUS_OK) |-> (res.address == '0))
    else $error("failed request returns a nonzero address");

  // The divider only finishes while a free request waits on it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == bpa_pkg::ST_DIV))
    else $error("divider finished outside a free request");

endmodule

`default_nettype wire

/* tb/bpa_tb_pkg.sv */
// Request and register codes shared by the allocator testbench files.
`timescale 1ns / 100ps

package bpa_tb_pkg;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic REGION_LOW = 1'b0;
  localparam logic REGION_MED = 1'b1;

  // Register indexes with no register behind them; writes there must be ignored.
  localparam logic [bpa_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
  localparam logic [bpa_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

endpackage

/* tb/bpa_checker.sv */
// Checker that predicts every allocator result and compares it with the block's output.
`timescale 1ns / 100ps

module bpa_checker #(
  parameter int BITMAP_BYTES = 131072,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          mode,
  input  logic                          region,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_address,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bpa_pkg::ADDR_W-1:0]    result_address,
  input  logic [1:0]                    status,
  output int                            mismatches,
  output int                            results_due
);

  logic [7:0]    page_taken [BITMAP_BYTES];
  bpa_pkg::cfg_t bounds;
  bpa_pkg::res_t pending_results[$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  // First fit: the first byte that is not full, then its first clear bit from the top.
  function automatic bpa_pkg::res_t claim_page(logic sel);
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   pos;
    int            bitpos;
    bpa_pkg::res_t r;
    lo = (sel == bpa_tb_pkg::REGION_MED) ? bounds.med_start : bounds.low_start;
    hi = (sel == bpa_tb_pkg::REGION_MED) ? bounds.med_stop : bounds.low_stop;
    r.address = '0;
    r.status  = bpa_pkg::STATUS_OOM;
    if (hi > BITMAP_BYTES) hi = BITMAP_BYTES;
    for (pos = lo; pos < hi; pos++) begin
      if (page_taken[pos] != bpa_pkg::BYTE_FULL) begin
        bitpos = 0;
        while (page_taken[pos][7 - bitpos]) bitpos++;
        page_taken[pos] = page_taken[pos] | (bpa_pkg::FIRST_BIT >> bitpos);
        r.address = bpa_pkg::ADDR_W'((longint'(pos) * 8 + bitpos) * PAGE_BYTES);
        r.status  = bpa_pkg::STATUS_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic bpa_pkg::res_t release_page(logic [bpa_pkg::ADDR_W-1:0] addr);
    longint unsigned page;
    longint unsigned idx;
    int              bitpos;
    bpa_pkg::res_t   r;
    page      = longint'(addr) / PAGE_BYTES;
    idx       = page / 8;
    bitpos    = int'(page % 8);
    r.address = '0;
    if (addr == '0 || addr >= bpa_pkg::FREE_LIMIT || idx >= BITMAP_BYTES) begin
      r.status = bpa_pkg::STATUS_RANGE;
    end else if (longint'(addr) % PAGE_BYTES != 0) begin
      r.status = bpa_pkg::STATUS_UNALIGNED;
    end else begin
      page_taken[idx] = page_taken[idx] & ~(bpa_pkg::FIRST_BIT >> bitpos);
      r.status = bpa_pkg::STATUS_OK;
    end
    return r;
  endfunction

  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    bpa_pkg::res_t want;
    if (rst) begin
      foreach (page_taken[i]) page_taken[i] = bpa_pkg::BYTE_FULL;
      bounds = bpa_pkg::CFG_RESET;
      pending_results.delete();
    end else begin
      // A result always belongs to a request accepted at an earlier edge, so pop first.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_error($sformatf("result with no request outstanding: address %h status %0d",
                               result_address, status));
        end else begin
          want = pending_results.pop_front();
          if (result_address !== want.address)
            note_error($sformatf("result_address expected %h got %h",
                                 want.address, result_address));
          if (status !== want.status)
            note_error($sformatf("status expected %0d got %0d", want.status, status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpa_pkg::REG_LOW_START: bounds.low_start = cfg_data;
          bpa_pkg::REG_LOW_STOP:  bounds.low_stop  = cfg_data;
          bpa_pkg::REG_MED_START: bounds.med_start = cfg_data;
          bpa_pkg::REG_MED_STOP:  bounds.med_stop  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(mode == bpa_tb_pkg::MODE_FREE ? release_page(page_address)
                                                                : claim_page(region));
    end
    results_due = pending_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAP_BYTES       = 131072;
  localparam int PAGE_LEN        = 4096;
  localparam int RANDOM_REQUESTS = 830;
  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PRESSURE_AFTER  = 200;
  localparam int PRESSURE_CYCLES = 400;
  localparam int REG_W           = bpa_pkg::REG_W;
  localparam int ADDR_W          = bpa_pkg::ADDR_W;
  localparam int CFG_IDX_W       = bpa_pkg::CFG_IDX_W;
  localparam logic [REG_W-1:0] REG_MAX = '1;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [REG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 mode         = bpa_tb_pkg::MODE_ALLOC;
  logic                 region       = bpa_tb_pkg::REGION_LOW;
  logic [ADDR_W-1:0]    page_address = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [ADDR_W-1:0]    result_address;
  logic [1:0]           status;

  int   mismatches;
  int   results_due;
  int   results_seen = 0;
  int   cycle_count  = 0;
  bit   burst_phase  = 1'b0;
  logic [REG_W-1:0] win_lo [2];
  logic [REG_W-1:0] win_hi [2];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  bitmap_page_allocator_top #(
    .BITMAP_BYTES(MAP_BYTES),
    .PAGE_BYTES  (PAGE_LEN)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .region(region), .page_address(page_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .status(status)
  );

  bpa_checker #(
    .BITMAP_BYTES(MAP_BYTES),
    .PAGE_BYTES  (PAGE_LEN)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .region(region), .page_address(page_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .status(status),
    .mismatches(mismatches), .results_due(results_due)
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_page_allocator_top regression: fail");
      $finish;
    end
  end

  // Mostly back to back, some short pauses and a few long ones.
  function automatic int pick_gap(bit allow_idle);
    int r;
    r = $urandom_range(0, 99);
    if (!allow_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_request(logic m, logic sel, logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap(!burst_phase);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    region       <= sel;
    page_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Windows stay narrow so that every scan is short.
  task automatic pick_window(output logic [REG_W-1:0] lo, output logic [REG_W-1:0] hi);
    int base;
    int width;
    int shape;
    base  = $urandom_range(0, MAP_BYTES - 1);
    width = $urandom_range(1, 40);
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      lo = REG_W'(base);
      hi = REG_W'(base);
    end else if (shape == 1) begin
      lo = REG_W'(base + width);
      hi = REG_W'(base);
    end else if (shape == 2) begin
      lo = REG_W'(MAP_BYTES - width);
      hi = REG_MAX;
    end else begin
      lo = REG_W'(base);
      hi = REG_W'(base + width);
    end
  endtask

  // A page inside the current window of a region, sometimes one byte past its end.
  function automatic logic [ADDR_W-1:0] page_in_window(logic sel);
    int unsigned span;
    int unsigned pos;
    span = (win_hi[sel] > win_lo[sel]) ? win_hi[sel] - win_lo[sel] : 1;
    if (span > 64) span = 64;
    pos = win_lo[sel] + $urandom_range(0, span);
    return ADDR_W'((longint'(pos) * 8 + $urandom_range(0, 7)) * PAGE_LEN);
  endfunction

  // Result receiver, with one long hold-off so that the block backs up into its input.
  initial begin
    int gap;
    bit pressure_done;
    pressure_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AFTER && in_valid) begin
        out_ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      gap = pick_gap(1'b1);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    logic             sel;
    int               kind;
    int               burst_len;
    int               left;
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset bounds with a full bitmap: both regions are out of memory, the medium one
    // only after scanning to the end of the bitmap; then frees and reallocations.
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_LOW, '0);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_MED, '1);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_MED, '0);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, bpa_pkg::FREE_LIMIT);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, '1);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, ADDR_W'(PAGE_LEN - 1));
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, bpa_pkg::FREE_LIMIT - 1);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, ADDR_W'(PAGE_LEN));
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_MED, ADDR_W'(PAGE_LEN));
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, ADDR_W'(512 * 8 * PAGE_LEN));
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW,
                 bpa_pkg::FREE_LIMIT - PAGE_LEN);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_LOW, '1);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_MED, '0);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_LOW, '0);

    // Bounds at their extremes, a medium end past the bitmap, and writes to spare indexes.
    wait_idle();
    write_reg(bpa_pkg::REG_LOW_START, '0);
    write_reg(bpa_pkg::REG_LOW_STOP, REG_W'(MAP_BYTES));
    write_reg(bpa_pkg::REG_MED_START, REG_W'(MAP_BYTES - 1));
    write_reg(bpa_pkg::REG_MED_STOP, REG_MAX);
    write_reg(bpa_tb_pkg::REG_SPARE_LAST, REG_MAX);
    write_reg(bpa_tb_pkg::REG_SPARE_FIRST, '0);
    cfg_valid <= 1'b0;
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW, ADDR_W'(3 * PAGE_LEN));
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_LOW, '0);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_MED, '0);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_MED, '0);

    // Empty and inverted regions.
    wait_idle();
    write_reg(bpa_pkg::REG_MED_START, REG_MAX);
    write_reg(bpa_pkg::REG_LOW_START, REG_W'(100));
    write_reg(bpa_pkg::REG_LOW_STOP, REG_W'(50));
    cfg_valid <= 1'b0;
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_MED, '0);
    send_request(bpa_tb_pkg::MODE_ALLOC, bpa_tb_pkg::REGION_LOW, '0);
    send_request(bpa_tb_pkg::MODE_FREE, bpa_tb_pkg::REGION_LOW,
                 bpa_pkg::FREE_LIMIT + PAGE_LEN);

    left = RANDOM_REQUESTS;
    while (left > 0) begin
      wait_idle();
      pick_window(lo, hi);
      win_lo[bpa_tb_pkg::REGION_LOW] = lo;
      win_hi[bpa_tb_pkg::REGION_LOW] = hi;
      if ($urandom_range(0, 5) == 0) begin
        win_lo[bpa_tb_pkg::REGION_MED] = lo;
        win_hi[bpa_tb_pkg::REGION_MED] = hi;
      end else begin
        pick_window(lo, hi);
        win_lo[bpa_tb_pkg::REGION_MED] = lo;
        win_hi[bpa_tb_pkg::REGION_MED] = hi;
      end
      write_reg(bpa_pkg::REG_LOW_START, win_lo[bpa_tb_pkg::REGION_LOW]);
      write_reg(bpa_pkg::REG_LOW_STOP, win_hi[bpa_tb_pkg::REGION_LOW]);
      write_reg(bpa_pkg::REG_MED_START, win_lo[bpa_tb_pkg::REGION_MED]);
      write_reg(bpa_pkg::REG_MED_STOP, win_hi[bpa_tb_pkg::REGION_MED]);
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(bpa_tb_pkg::REG_SPARE_FIRST,
                                            bpa_tb_pkg::REG_SPARE_LAST)),
                  REG_W'($urandom()));
      cfg_valid <= 1'b0;

      burst_phase = ($urandom_range(0, 4) == 0);
      burst_len   = $urandom_range(15, 50);
      if (burst_len > left) burst_len = left;
      // Frees inside the windows keep allocations succeeding; the rest is noise.
      repeat (burst_len) begin
        kind = $urandom_range(0, 99);
        sel  = 1'($urandom_range(0, 1));
        if (kind < 40)
          send_request(bpa_tb_pkg::MODE_ALLOC, sel, $urandom());
        else if (kind < 80)
          send_request(bpa_tb_pkg::MODE_FREE, sel, page_in_window(sel));
        else if (kind < 90)
          send_request(bpa_tb_pkg::MODE_FREE, sel,
                       page_in_window(sel) | ADDR_W'($urandom_range(1, PAGE_LEN - 1)));
        else
          send_request(bpa_tb_pkg::MODE_FREE, sel, $urandom());
      end
      left -= burst_len;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("bitmap_page_allocator_top regression: pass");
    else
      $display("bitmap_page_allocator_top regression: fail");
    $finish;
  end

endmodule
